// ===== src/rwhp_pkg.sv =====
// rwhp_pkg: shared types and constants for the RIFF/WAVE header parser.
// Used by every module under src; depends on nothing.
`default_nettype none
package rwhp_pkg;

    localparam int OFFSET_BITS_DEF = 32;
    localparam int WALK_W          = 34;
    localparam int Q_DEPTH         = 2;
    localparam int Q_PTR_W         = 1;
    localparam int DIV_STEPS       = 32;
    localparam int FRAME_W         = 29;

    localparam logic [31:0] RIFF_TAG = 32'h4646_4952;
    localparam logic [31:0] WAVE_TAG = 32'h4556_4157;
    localparam logic [31:0] FMT_TAG  = 32'h2074_6D66;
    localparam logic [31:0] DATA_TAG = 32'h6174_6164;
    localparam logic [31:0] CUE_TAG  = 32'h2065_7563;

    localparam int LAST_SHORT_POS = 43;
    localparam int HDR_LEN        = 8;
    localparam int FMT_MIN_LEN    = 16;
    localparam int FMT_BITS_LO    = 14;
    localparam int FMT_BITS_HI    = 15;
    localparam int CUE_MIN_LEN    = 24;
    localparam int CUE_LOOP_OFS   = 20;
    localparam int CUE_LOOP_END   = 24;
    localparam int PCM_FORMAT     = 1;
    localparam int WAVE_POS       = 8;
    localparam int WAVE_END       = 12;
    localparam int RIFF_END       = 4;
    localparam int WALK_START     = 12;

    typedef enum logic [2:0] {
        ST_OK,
        ST_SHORT,
        ST_NO_RIFF,
        ST_NO_WAVE,
        ST_NO_FMT,
        ST_NOT_PCM,
        ST_NO_DATA,
        ST_ZERO_FRAME
    } status_t;

    typedef enum logic [2:0] {
        BK_IDLE,
        BK_MUL,
        BK_CHECK,
        BK_DIV,
        BK_DONE
    } back_state_t;

    typedef struct packed {
        status_t     status;
        logic [15:0] chans;
        logic [31:0] rate;
        logic [12:0] width;
        logic [31:0] data_length;
        logic [31:0] data_offset;
        logic [31:0] loop;
    } job_t;

endpackage
`default_nettype wire

// ===== src/rwhp_front.sv =====
// rwhp_front: byte-level front end; checks tags, walks chunks, captures fields.
// Pushes one summary job per file into the queue. Depends on rwhp_pkg.
`default_nettype none
module rwhp_front #(
    parameter int OFFSET_BITS = rwhp_pkg::OFFSET_BITS_DEF
) (
    input  wire                 aclk,
    input  wire                 aresetn,
    input  wire                 s_valid,
    output logic                s_ready,
    input  wire  [7:0]          s_data_byte,
    input  wire                 s_last_byte,
    output logic                job_valid,
    input  wire                 job_ready,
    output rwhp_pkg::job_t      job
);

    localparam int PW = OFFSET_BITS + 1;
    localparam int WW = rwhp_pkg::WALK_W;

    logic [PW-1:0]  pos_reg, pos_next;
    logic [1:0]     tag_ok_reg, tag_ok_next;
    logic [55:0]    hdr_reg, hdr_next;
    logic [WW-1:0]  chunk_reg, chunk_next;
    logic [2:0]     found_reg, found_next;
    logic [PW-1:0]  fmt_start_reg, fmt_start_next;
    logic [PW-1:0]  data_start_reg, data_start_next;
    logic [PW-1:0]  cue_start_reg, cue_start_next;
    logic [31:0]    fmt_len_reg, fmt_len_next;
    logic [31:0]    data_len_reg, data_len_next;
    logic [31:0]    cue_len_reg, cue_len_next;
    logic [63:0]    fmt_fields_reg, fmt_fields_next;
    logic [15:0]    fmt_bits_reg, fmt_bits_next;
    logic [31:0]    cue_val_reg, cue_val_next;

    logic           accept;
    logic           in_range;
    logic [PW-1:0]  pos_ext;
    logic [PW-1:0]  fmt_off;
    logic [PW-1:0]  cue_off;
    logic [PW-1:0]  payload;
    logic [WW-1:0]  wpos;
    logic [WW-1:0]  hdr_diff;
    logic [2:0]     hoff;
    logic           in_hdr;
    logic [31:0]    hdr_tag;
    logic [31:0]    hdr_len;
    logic [32:0]    padded;
    rwhp_pkg::status_t pre_status;
    logic           reported;

    assign s_ready   = job_ready;
    assign accept    = s_valid & s_ready;
    assign job_valid = accept & s_last_byte;

    assign in_range = ~pos_reg[PW-1];
    assign pos_ext  = {1'b0, pos_reg[PW-2:0]};
    assign fmt_off  = pos_ext - fmt_start_reg;
    assign cue_off  = pos_ext - cue_start_reg;
    assign payload  = pos_ext + PW'(1);
    assign wpos     = WW'(pos_ext);
    assign hdr_diff = wpos - chunk_reg;
    assign hoff     = hdr_diff[2:0];
    assign in_hdr   = (wpos >= chunk_reg) && (hdr_diff < WW'(rwhp_pkg::HDR_LEN));
    assign hdr_tag  = hdr_reg[31:0];
    assign hdr_len  = {s_data_byte, hdr_reg[55:32]};
    assign padded   = ({1'b0, hdr_len} + 33'd1) & ~33'd1;

    always_comb begin
        pos_next        = pos_reg;
        tag_ok_next     = tag_ok_reg;
        hdr_next        = hdr_reg;
        chunk_next      = chunk_reg;
        found_next      = found_reg;
        fmt_start_next  = fmt_start_reg;
        data_start_next = data_start_reg;
        cue_start_next  = cue_start_reg;
        fmt_len_next    = fmt_len_reg;
        data_len_next   = data_len_reg;
        cue_len_next    = cue_len_reg;
        fmt_fields_next = fmt_fields_reg;
        fmt_bits_next   = fmt_bits_reg;
        cue_val_next    = cue_val_reg;
        if (in_range) begin
            pos_next = pos_reg + PW'(1);
            if (pos_ext < PW'(rwhp_pkg::RIFF_END)
                    && s_data_byte != rwhp_pkg::RIFF_TAG[8*pos_ext[1:0] +: 8]) begin
                tag_ok_next[0] = 1'b0;
            end
            if (pos_ext >= PW'(rwhp_pkg::WAVE_POS) && pos_ext < PW'(rwhp_pkg::WAVE_END)
                    && s_data_byte != rwhp_pkg::WAVE_TAG[8*pos_ext[1:0] +: 8]) begin
                tag_ok_next[1] = 1'b0;
            end
            if (found_reg[0] && pos_ext >= fmt_start_reg) begin
                if (fmt_off < PW'(8)) begin
                    fmt_fields_next[8*fmt_off[2:0] +: 8] = s_data_byte;
                end else if (fmt_off == PW'(rwhp_pkg::FMT_BITS_LO)) begin
                    fmt_bits_next[7:0] = s_data_byte;
                end else if (fmt_off == PW'(rwhp_pkg::FMT_BITS_HI)) begin
                    fmt_bits_next[15:8] = s_data_byte;
                end
            end
            if (found_reg[2] && pos_ext >= cue_start_reg
                    && cue_off >= PW'(rwhp_pkg::CUE_LOOP_OFS)
                    && cue_off < PW'(rwhp_pkg::CUE_LOOP_END)) begin
                cue_val_next[8*cue_off[1:0] +: 8] = s_data_byte;
            end
            if (in_hdr) begin
                if (hoff != 3'd7) begin
                    hdr_next[8*hoff +: 8] = s_data_byte;
                end else begin
                    if (hdr_tag == rwhp_pkg::FMT_TAG && !found_reg[0]) begin
                        found_next[0]  = 1'b1;
                        fmt_start_next = payload;
                        fmt_len_next   = hdr_len;
                    end else if (hdr_tag == rwhp_pkg::DATA_TAG && !found_reg[1]) begin
                        found_next[1]   = 1'b1;
                        data_start_next = payload;
                        data_len_next   = hdr_len;
                    end else if (hdr_tag == rwhp_pkg::CUE_TAG && !found_reg[2]) begin
                        found_next[2]  = 1'b1;
                        cue_start_next = payload;
                        cue_len_next   = hdr_len;
                    end
                    chunk_next = WW'(payload) + WW'(padded);
                    hdr_next   = '0;
                end
            end
        end
    end

    always_comb begin
        priority if (pos_reg < PW'(rwhp_pkg::LAST_SHORT_POS)) begin
            pre_status = rwhp_pkg::ST_SHORT;
        end else if (!tag_ok_next[0]) begin
            pre_status = rwhp_pkg::ST_NO_RIFF;
        end else if (!tag_ok_next[1]) begin
            pre_status = rwhp_pkg::ST_NO_WAVE;
        end else if (!found_next[0] || fmt_len_next < 32'(rwhp_pkg::FMT_MIN_LEN)) begin
            pre_status = rwhp_pkg::ST_NO_FMT;
        end else if (fmt_fields_next[15:0] != 16'(rwhp_pkg::PCM_FORMAT)) begin
            pre_status = rwhp_pkg::ST_NOT_PCM;
        end else if (!found_next[1]) begin
            pre_status = rwhp_pkg::ST_NO_DATA;
        end else begin
            pre_status = rwhp_pkg::ST_OK;
        end
    end

    assign reported = (pre_status == rwhp_pkg::ST_OK) || (pre_status == rwhp_pkg::ST_NO_DATA);

    always_comb begin
        job             = '0;
        job.status      = pre_status;
        job.chans       = reported ? fmt_fields_next[31:16] : 16'd0;
        job.rate        = reported ? fmt_fields_next[63:32] : 32'd0;
        job.width       = reported ? fmt_bits_next[15:3] : 13'd0;
        job.data_length = data_len_next;
        job.data_offset = (pre_status == rwhp_pkg::ST_OK) ? 32'(data_start_next) : 32'd0;
        job.loop        = ((pre_status == rwhp_pkg::ST_OK)
                           && cue_len_next >= 32'(rwhp_pkg::CUE_MIN_LEN)) ? cue_val_next : '1;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn || (accept && s_last_byte)) begin
            pos_reg        <= '0;
            tag_ok_reg     <= 2'b11;
            hdr_reg        <= '0;
            chunk_reg      <= WW'(rwhp_pkg::WALK_START);
            found_reg      <= '0;
            fmt_start_reg  <= '0;
            data_start_reg <= '0;
            cue_start_reg  <= '0;
            fmt_len_reg    <= '0;
            data_len_reg   <= '0;
            cue_len_reg    <= '0;
            fmt_fields_reg <= '0;
            fmt_bits_reg   <= '0;
            cue_val_reg    <= '0;
        end else if (accept) begin
            pos_reg        <= pos_next;
            tag_ok_reg     <= tag_ok_next;
            hdr_reg        <= hdr_next;
            chunk_reg      <= chunk_next;
            found_reg      <= found_next;
            fmt_start_reg  <= fmt_start_next;
            data_start_reg <= data_start_next;
            cue_start_reg  <= cue_start_next;
            fmt_len_reg    <= fmt_len_next;
            data_len_reg   <= data_len_next;
            cue_len_reg    <= cue_len_next;
            fmt_fields_reg <= fmt_fields_next;
            fmt_bits_reg   <= fmt_bits_next;
            cue_val_reg    <= cue_val_next;
        end
    end

endmodule
`default_nettype wire

// ===== src/rwhp_queue.sv =====
// rwhp_queue: short job queue between the front end and the back end.
// Depends on rwhp_pkg for the job type and depth.
`default_nettype none
module rwhp_queue (
    input  wire                 aclk,
    input  wire                 aresetn,
    input  wire                 wr_valid,
    output logic                wr_ready,
    input  rwhp_pkg::job_t      wr_job,
    output logic                rd_valid,
    input  wire                 rd_ready,
    output rwhp_pkg::job_t      rd_job
);

    localparam int PTR_W = rwhp_pkg::Q_PTR_W;

    rwhp_pkg::job_t     mem [rwhp_pkg::Q_DEPTH];
    logic [PTR_W-1:0]   wr_ptr_reg;
    logic [PTR_W-1:0]   rd_ptr_reg;
    logic [PTR_W:0]     count_reg, count_next;
    logic               push;
    logic               pop;

    assign wr_ready = (count_reg != (PTR_W+1)'(rwhp_pkg::Q_DEPTH));
    assign rd_valid = (count_reg != '0);
    assign push     = wr_valid & wr_ready;
    assign pop      = rd_valid & rd_ready;
    assign rd_job   = mem[rd_ptr_reg];

    always_comb begin
        count_next = count_reg;
        if (push && !pop) begin
            count_next = count_reg + (PTR_W+1)'(1);
        end else if (pop && !push) begin
            count_next = count_reg - (PTR_W+1)'(1);
        end
    end

    always_ff @(posedge aclk) begin
        if (push) begin
            mem[wr_ptr_reg] <= wr_job;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            if (push) begin
                wr_ptr_reg <= wr_ptr_reg + PTR_W'(1);
            end
            if (pop) begin
                rd_ptr_reg <= rd_ptr_reg + PTR_W'(1);
            end
            count_reg <= count_next;
        end
    end

endmodule
`default_nettype wire

// ===== src/rwhp_back.sv =====
// rwhp_back: back end; frame size multiply, serial frame-count divide, result register.
// Takes jobs from rwhp_queue. Depends on rwhp_pkg.
`default_nettype none
module rwhp_back (
    input  wire                 aclk,
    input  wire                 aresetn,
    input  wire                 q_valid,
    output logic                q_ready,
    input  rwhp_pkg::job_t      q_job,
    output logic                m_valid,
    input  wire                 m_ready,
    output logic [2:0]          m_status,
    output logic [15:0]         m_channel_count,
    output logic [31:0]         m_sample_rate,
    output logic [12:0]         m_bytes_per_sample,
    output logic [31:0]         m_frame_count,
    output logic [31:0]         m_data_offset,
    output logic signed [31:0]  m_loop_start
);

    localparam int FW = rwhp_pkg::FRAME_W;

    rwhp_pkg::back_state_t  state_reg, state_next;
    rwhp_pkg::job_t         job_reg;
    logic [FW-1:0]          frame_reg;
    logic                   zf_reg;
    logic [FW-1:0]          rem_reg;
    logic [31:0]            quo_reg;
    logic [4:0]             cnt_reg;
    logic                   m_valid_reg;
    logic [2:0]             status_reg;
    logic [15:0]            chans_reg;
    logic [31:0]            rate_reg;
    logic [12:0]            width_reg;
    logic [31:0]            frames_reg;
    logic [31:0]            dofs_reg;
    logic [31:0]            loop_reg;

    logic                   pop;
    logic                   out_load;
    logic                   div_last;
    logic [FW:0]            trial;
    logic [FW:0]            diff;
    logic                   ge;

    assign trial    = {rem_reg, quo_reg[31]};
    assign diff     = trial - {1'b0, frame_reg};
    assign ge       = (trial >= {1'b0, frame_reg});
    assign div_last = (cnt_reg == 5'(rwhp_pkg::DIV_STEPS - 1));

    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            rwhp_pkg::BK_IDLE: begin
                if (q_valid) begin
                    state_next = (q_job.status == rwhp_pkg::ST_OK)
                                 ? rwhp_pkg::BK_MUL : rwhp_pkg::BK_DONE;
                end
            end
            rwhp_pkg::BK_MUL: begin
                state_next = rwhp_pkg::BK_CHECK;
            end
            rwhp_pkg::BK_CHECK: begin
                state_next = (frame_reg == '0) ? rwhp_pkg::BK_DONE : rwhp_pkg::BK_DIV;
            end
            rwhp_pkg::BK_DIV: begin
                if (div_last) begin
                    state_next = rwhp_pkg::BK_DONE;
                end
            end
            rwhp_pkg::BK_DONE: begin
                if (!m_valid_reg || m_ready) begin
                    state_next = rwhp_pkg::BK_IDLE;
                end
            end
            default: state_next = rwhp_pkg::BK_IDLE;
        endcase
    end

    always_comb begin
        pop      = (state_reg == rwhp_pkg::BK_IDLE) && q_valid;
        out_load = (state_reg == rwhp_pkg::BK_DONE) && (!m_valid_reg || m_ready);
    end

    assign q_ready = pop;

    always_ff @(posedge aclk) begin
        if (pop) begin
            job_reg <= q_job;
            zf_reg  <= 1'b0;
        end
        if (state_reg == rwhp_pkg::BK_MUL) begin
            frame_reg <= FW'(job_reg.width) * FW'(job_reg.chans);
        end
        if (state_reg == rwhp_pkg::BK_CHECK) begin
            zf_reg  <= (frame_reg == '0);
            rem_reg <= '0;
            quo_reg <= job_reg.data_length;
            cnt_reg <= '0;
        end
        if (state_reg == rwhp_pkg::BK_DIV) begin
            rem_reg <= ge ? diff[FW-1:0] : trial[FW-1:0];
            quo_reg <= {quo_reg[30:0], ge};
            cnt_reg <= cnt_reg + 5'd1;
        end
        if (out_load) begin
            status_reg <= zf_reg ? rwhp_pkg::ST_ZERO_FRAME : job_reg.status;
            chans_reg  <= job_reg.chans;
            rate_reg   <= job_reg.rate;
            width_reg  <= job_reg.width;
            frames_reg <= ((job_reg.status == rwhp_pkg::ST_OK) && !zf_reg) ? quo_reg : 32'd0;
            dofs_reg   <= zf_reg ? 32'd0 : job_reg.data_offset;
            loop_reg   <= zf_reg ? '1 : job_reg.loop;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= rwhp_pkg::BK_IDLE;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg <= state_next;
            if (out_load) begin
                m_valid_reg <= 1'b1;
            end else if (m_ready) begin
                m_valid_reg <= 1'b0;
            end
        end
    end

    assign m_valid            = m_valid_reg;
    assign m_status           = status_reg;
    assign m_channel_count    = chans_reg;
    assign m_sample_rate      = rate_reg;
    assign m_bytes_per_sample = width_reg;
    assign m_frame_count      = frames_reg;
    assign m_data_offset      = dofs_reg;
    assign m_loop_start       = $signed(loop_reg);

endmodule
`default_nettype wire

// ===== src/riff_wav_header_parser.sv =====
// riff_wav_header_parser: top level; front end, job queue and back end. Uses rwhp_pkg.
// Throughput: one byte per cycle; the front end stalls only while the two-entry queue is full.
// From the last byte: queue, then IDLE and DONE for an error status, plus MUL and CHECK for zero
// frame size, plus the one-bit-per-cycle 32-step frame-count divider for a good file.
// Reset: synchronous active-low aresetn clears walk state, queue and the result valid flag.
`default_nettype none
module riff_wav_header_parser #(
    parameter int OFFSET_BITS = rwhp_pkg::OFFSET_BITS_DEF
) (
    input  wire                 aclk,
    input  wire                 aresetn,
    input  wire                 s_valid,
    output logic                s_ready,
    input  wire  [7:0]          s_data_byte,
    input  wire                 s_last_byte,
    output logic                m_valid,
    input  wire                 m_ready,
    output logic [2:0]          m_status,
    output logic [15:0]         m_channel_count,
    output logic [31:0]         m_sample_rate,
    output logic [12:0]         m_bytes_per_sample,
    output logic [31:0]         m_frame_count,
    output logic [31:0]         m_data_offset,
    output logic signed [31:0]  m_loop_start
);

    logic               fq_valid;
    logic               fq_ready;
    rwhp_pkg::job_t     fq_job;
    logic               qb_valid;
    logic               qb_ready;
    rwhp_pkg::job_t     qb_job;

    rwhp_front #(
        .OFFSET_BITS (OFFSET_BITS)
    ) u_front (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .s_valid     (s_valid),
        .s_ready     (s_ready),
        .s_data_byte (s_data_byte),
        .s_last_byte (s_last_byte),
        .job_valid   (fq_valid),
        .job_ready   (fq_ready),
        .job         (fq_job)
    );

    rwhp_queue u_queue (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .wr_valid (fq_valid),
        .wr_ready (fq_ready),
        .wr_job   (fq_job),
        .rd_valid (qb_valid),
        .rd_ready (qb_ready),
        .rd_job   (qb_job)
    );

    rwhp_back u_back (
        .aclk               (aclk),
        .aresetn            (aresetn),
        .q_valid            (qb_valid),
        .q_ready            (qb_ready),
        .q_job              (qb_job),
        .m_valid            (m_valid),
        .m_ready            (m_ready),
        .m_status           (m_status),
        .m_channel_count    (m_channel_count),
        .m_sample_rate      (m_sample_rate),
        .m_bytes_per_sample (m_bytes_per_sample),
        .m_frame_count      (m_frame_count),
        .m_data_offset      (m_data_offset),
        .m_loop_start       (m_loop_start)
    );

endmodule
`default_nettype wire

// ===== src/rwhp_checker.sv =====
// rwhp_checker: port-level assertions for riff_wav_header_parser, bound to the top level.
// Depends on rwhp_pkg for status codes.
`default_nettype none
module rwhp_checker (
    input wire                  aclk,
    input wire                  aresetn,
    input wire                  s_valid,
    input wire                  s_ready,
    input wire [7:0]            s_data_byte,
    input wire                  s_last_byte,
    input wire                  m_valid,
    input wire                  m_ready,
    input wire [2:0]            m_status,
    input wire [15:0]           m_channel_count,
    input wire [31:0]           m_sample_rate,
    input wire [12:0]           m_bytes_per_sample,
    input wire [31:0]           m_frame_count,
    input wire [31:0]           m_data_offset,
    input wire signed [31:0]    m_loop_start
);

    logic early_err;
    logic s_unused;

    assign early_err = (m_status == rwhp_pkg::ST_SHORT) || (m_status == rwhp_pkg::ST_NO_RIFF)
                    || (m_status == rwhp_pkg::ST_NO_WAVE) || (m_status == rwhp_pkg::ST_NO_FMT)
                    || (m_status == rwhp_pkg::ST_NOT_PCM);
    assign s_unused  = s_valid & s_ready & s_last_byte & (s_data_byte != 8'd0);

    a_reset_clears: assert property (@(posedge aclk) !aresetn |=> !m_valid)
        else $error("result valid after reset");

    a_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_frame_count) && $stable(m_status))
        else $error("stalled result dropped or changed");

    a_fail_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_status != rwhp_pkg::ST_OK |->
            m_frame_count == 32'd0 && m_data_offset == 32'd0 && m_loop_start == -32'sd1)
        else $error("failed file reports frames, offset or loop");

    a_early_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && early_err |->
            m_channel_count == 16'd0 && m_sample_rate == 32'd0 && m_bytes_per_sample == 13'd0)
        else $error("format fields reported before fmt was validated");

    a_zero_frame: assert property (@(posedge aclk) disable iff (!aresetn || s_unused)
        m_valid && m_status == rwhp_pkg::ST_ZERO_FRAME |->
            m_bytes_per_sample == 13'd0 || m_channel_count == 16'd0)
        else $error("zero frame status with nonzero frame size");

endmodule

bind riff_wav_header_parser rwhp_checker u_rwhp_checker (.*);
`default_nettype wire
